>>> hw/rtl/csb_pkg.sv
// ----------------------------------------------------------------------------
// csb_pkg
// Shared constants, sequence codes, command/status types and saturating
// helpers for the circle segment bounce core.
// ----------------------------------------------------------------------------
package csb_pkg;

    localparam int MAX_WALLS = 16;
    localparam int WIDX_W    = $clog2(MAX_WALLS);
    localparam int CNT_W     = $clog2(MAX_WALLS + 1);
    localparam int PW        = 50;   // scaled product width (66 - 16)
    localparam int SW        = 52;   // width of sums before saturation
    localparam int QW        = 49;   // dividend / quotient width
    localparam int DIV_LAST  = QW - 1;

    // sequence codes: controller state, also the datapath operation
    localparam logic [5:0] ST_IDLE     = 6'd0;
    localparam logic [5:0] ST_READ     = 6'd1;
    localparam logic [5:0] ST_DIFF     = 6'd2;
    localparam logic [5:0] ST_M_UXUX   = 6'd3;
    localparam logic [5:0] ST_M_UYUY   = 6'd4;
    localparam logic [5:0] ST_M_UYACX  = 6'd5;
    localparam logic [5:0] ST_CHK_UU   = 6'd6;
    localparam logic [5:0] ST_M_UXACY  = 6'd7;
    localparam logic [5:0] ST_M_RR     = 6'd8;
    localparam logic [5:0] ST_M_CC     = 6'd9;
    localparam logic [5:0] ST_M_R2UU   = 6'd10;
    localparam logic [5:0] ST_S_RHS    = 6'd11;
    localparam logic [5:0] ST_CHK_LINE = 6'd12;
    localparam logic [5:0] ST_M_UXACX  = 6'd13;
    localparam logic [5:0] ST_M_UYACY  = 6'd14;
    localparam logic [5:0] ST_M_UXBCX  = 6'd15;
    localparam logic [5:0] ST_M_UYBCY  = 6'd16;
    localparam logic [5:0] ST_M_ACX2   = 6'd17;
    localparam logic [5:0] ST_M_ACY2   = 6'd18;
    localparam logic [5:0] ST_M_BCX2   = 6'd19;
    localparam logic [5:0] ST_M_BCY2   = 6'd20;
    localparam logic [5:0] ST_S_B2     = 6'd21;
    localparam logic [5:0] ST_CHK_SEG  = 6'd22;
    localparam logic [5:0] ST_M_VXWX   = 6'd23;
    localparam logic [5:0] ST_M_VYWY   = 6'd24;
    localparam logic [5:0] ST_S_D      = 6'd25;
    localparam logic [5:0] ST_DIV_INIT = 6'd26;
    localparam logic [5:0] ST_DIV_STEP = 6'd27;
    localparam logic [5:0] ST_S_T      = 6'd28;
    localparam logic [5:0] ST_M_TWX    = 6'd29;
    localparam logic [5:0] ST_M_TWY    = 6'd30;
    localparam logic [5:0] ST_S_VY     = 6'd31;
    localparam logic [5:0] ST_NEXT     = 6'd32;
    localparam logic [5:0] ST_DONE     = 6'd33;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_BALL  = 1'b1;

    typedef struct packed {
        logic [5:0]        op;
        logic [WIDX_W-1:0] idx;
        logic              load_ball;
        logic              write_wall;
        logic              load_out;
    } cmd_t;

    typedef struct packed {
        logic uu_zero;
        logic line_hit;
        logic seg_hit;
    } status_t;

    localparam logic signed [SW-1:0] SAT_MAX = 52'sd2147483647;
    localparam logic signed [SW-1:0] SAT_MIN = -52'sd2147483648;

    // clip to signed 32 bits; bit 32 flags a clip
    function automatic logic [32:0] sat32(input logic signed [SW-1:0] x);
        logic [32:0] r;
        if (x > SAT_MAX) begin
            r = {1'b1, 32'h7fff_ffff};
        end else if (x < SAT_MIN) begin
            r = {1'b1, 32'h8000_0000};
        end else begin
            r = {1'b0, x[31:0]};
        end
        return r;
    endfunction

    function automatic logic signed [SW-1:0] ext32(input logic signed [31:0] v);
        return {{(SW-32){v[31]}}, v};
    endfunction

    function automatic logic signed [SW-1:0] extp(input logic signed [PW-1:0] v);
        return {{(SW-PW){v[PW-1]}}, v};
    endfunction

endpackage

>>> hw/rtl/circle_segment_bounce_core.sv
// ----------------------------------------------------------------------------
// circle_segment_bounce_core
// Bounces a ball off a table of wall segments in Q16.16 fixed point.
// ----------------------------------------------------------------------------
//  channel  | direction | carries
//  s_*      | in        | wall write (req_type 0) or ball (req_type 1)
//  m_*      | out       | final velocity, hit count, saturation flag
//  wall_*   | in        | wall count register write
//
//  A wall write is taken while idle. A ball walks the table one wall at a time:
//  a wall is rejected for zero length, then on the line test, then on the
//  segment test, and otherwise bounces the ball by way of the divider.
//  One shared multiplier and a one-bit-per-cycle divider serve every step.
//  Reset is synchronous and active low; the wall table keeps no reset.
//  A result waiting on m_ready holds the sequencer in its final state.
module circle_segment_bounce_core
    import csb_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_req_type,
    input  logic [3:0]         s_wall_index,
    input  logic signed [31:0] s_wall_start_x,
    input  logic signed [31:0] s_wall_start_y,
    input  logic signed [31:0] s_wall_end_x,
    input  logic signed [31:0] s_wall_end_y,
    input  logic signed [31:0] s_ball_x,
    input  logic signed [31:0] s_ball_y,
    input  logic [30:0]        s_ball_radius,
    input  logic signed [31:0] s_speed_in_x,
    input  logic signed [31:0] s_speed_in_y,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_speed_out_x,
    output logic signed [31:0] m_speed_out_y,
    output logic [4:0]         m_hit_count,
    output logic               m_saturated,
    input  logic               wall_count_wr_en,
    input  logic [4:0]         wall_count_wr_data
);

    cmd_t    cmd;
    status_t status;

    // sequencer
    csb_ctrl u_ctrl (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_req_type         (s_req_type),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .wall_count_wr_en   (wall_count_wr_en),
        .wall_count_wr_data (wall_count_wr_data),
        .status             (status),
        .cmd                (cmd)
    );

    // arithmetic and wall table
    csb_dp u_dp (
        .aclk           (aclk),
        .cmd            (cmd),
        .status         (status),
        .s_wall_index   (s_wall_index),
        .s_wall_start_x (s_wall_start_x),
        .s_wall_start_y (s_wall_start_y),
        .s_wall_end_x   (s_wall_end_x),
        .s_wall_end_y   (s_wall_end_y),
        .s_ball_x       (s_ball_x),
        .s_ball_y       (s_ball_y),
        .s_ball_radius  (s_ball_radius),
        .s_speed_in_x   (s_speed_in_x),
        .s_speed_in_y   (s_speed_in_y),
        .m_speed_out_x  (m_speed_out_x),
        .m_speed_out_y  (m_speed_out_y),
        .m_hit_count    (m_hit_count),
        .m_saturated    (m_saturated)
    );

endmodule

>>> hw/rtl/csb_ctrl.sv
// ----------------------------------------------------------------------------
// csb_ctrl
// Sequencer: walks each ball through the wall table, one shared multiplier
// step per state, and runs the restoring divider count.
// ----------------------------------------------------------------------------
module csb_ctrl
    import csb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    output logic        m_valid,
    input  logic        m_ready,
    input  logic        wall_count_wr_en,
    input  logic [4:0]  wall_count_wr_data,
    input  status_t     status,
    output cmd_t        cmd
);

    logic [5:0]       state_reg, state_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [5:0]       div_cnt_reg, div_cnt_next;
    logic [4:0]       wall_count_reg;
    logic             m_valid_reg, m_valid_next;
    logic [CNT_W-1:0] n_walls;
    logic [CNT_W-1:0] idx_inc;
    logic             accept;
    logic             out_free;

    // clamp the wall count to the table depth
    assign n_walls = (wall_count_reg > 5'(MAX_WALLS)) ? CNT_W'(MAX_WALLS)
                                                      : CNT_W'(wall_count_reg);
    assign idx_inc  = idx_reg + 1'b1;
    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    // sequence the wall walk
    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        div_cnt_next = div_cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd.op         = state_reg;
        cmd.idx        = idx_reg[WIDX_W-1:0];
        cmd.load_ball  = 1'b0;
        cmd.write_wall = 1'b0;
        cmd.load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_req_type == REQ_BALL) begin
                        cmd.load_ball = 1'b1;
                        idx_next      = '0;
                        state_next    = (n_walls == '0) ? ST_DONE : ST_READ;
                    end else begin
                        cmd.write_wall = 1'b1;
                    end
                end
            end
            ST_CHK_UU:   state_next = status.uu_zero ? ST_NEXT : ST_M_UXACY;
            ST_CHK_LINE: state_next = status.line_hit ? ST_M_UXACX : ST_NEXT;
            ST_CHK_SEG:  state_next = status.seg_hit ? ST_M_VXWX : ST_NEXT;
            ST_DIV_INIT: begin
                div_cnt_next = '0;
                state_next   = ST_DIV_STEP;
            end
            ST_DIV_STEP: begin
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == 6'(DIV_LAST)) begin
                    state_next = ST_S_T;
                end
            end
            ST_S_VY:     state_next = ST_NEXT;
            ST_NEXT: begin
                idx_next   = idx_inc;
                state_next = (idx_inc == n_walls) ? ST_DONE : ST_READ;
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_READ, ST_DIFF, ST_M_UXUX, ST_M_UYUY, ST_M_UYACX, ST_M_UXACY,
            ST_M_RR, ST_M_CC, ST_M_R2UU, ST_S_RHS, ST_M_UXACX, ST_M_UYACY,
            ST_M_UXBCX, ST_M_UYBCY, ST_M_ACX2, ST_M_ACY2, ST_M_BCX2,
            ST_M_BCY2, ST_S_B2, ST_M_VXWX, ST_M_VYWY, ST_S_D, ST_S_T,
            ST_M_TWX, ST_M_TWY: begin
                state_next = state_reg + 1'b1;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // advance control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            div_cnt_reg    <= '0;
            m_valid_reg    <= 1'b0;
            wall_count_reg <= '0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            div_cnt_reg <= div_cnt_next;
            m_valid_reg <= m_valid_next;
            if (wall_count_wr_en) begin
                wall_count_reg <= wall_count_wr_data;
            end
        end
    end

endmodule

>>> hw/rtl/csb_dp.sv
// ----------------------------------------------------------------------------
// csb_dp
// Datapath: wall table memory, one shared 33x33 multiplier, restoring
// divider, saturating adders and the result register.
// ----------------------------------------------------------------------------
module csb_dp
    import csb_pkg::*;
(
    input  logic                aclk,
    input  cmd_t                cmd,
    output status_t             status,
    input  logic [3:0]          s_wall_index,
    input  logic signed [31:0]  s_wall_start_x,
    input  logic signed [31:0]  s_wall_start_y,
    input  logic signed [31:0]  s_wall_end_x,
    input  logic signed [31:0]  s_wall_end_y,
    input  logic signed [31:0]  s_ball_x,
    input  logic signed [31:0]  s_ball_y,
    input  logic [30:0]         s_ball_radius,
    input  logic signed [31:0]  s_speed_in_x,
    input  logic signed [31:0]  s_speed_in_y,
    output logic signed [31:0]  m_speed_out_x,
    output logic signed [31:0]  m_speed_out_y,
    output logic [4:0]          m_hit_count,
    output logic                m_saturated
);

    logic [127:0] mem [MAX_WALLS];
    logic [127:0] mem_q_reg;

    logic signed [31:0] px_reg, py_reg, vx_reg, vy_reg;
    logic [30:0]        r_reg;
    logic signed [31:0] ux_reg, uy_reg, acx_reg, acy_reg, bcx_reg, bcy_reg;
    logic signed [31:0] uu_reg, cross_reg, r2_reg, lhs_reg, rhs_reg;
    logic signed [31:0] a2_reg, b2_reg, d_reg, t_reg;
    logic signed [PW-1:0] p_reg, q_reg;
    logic               d1ok_reg, d2ok_reg;
    logic               sat_reg, pend_reg;
    logic [4:0]         hits_reg;
    logic [QW-1:0]      nq_reg;
    logic [30:0]        rem_reg;
    logic               neg_reg;

    logic signed [31:0] sx, sy, ex, ey;
    logic signed [32:0] wx;
    logic signed [32:0] ma, mb;
    logic signed [65:0] prod;
    logic signed [PW-1:0] pscaled;
    logic signed [SW-1:0] sum_pq;
    logic [32:0] s_ux, s_uy, s_acx, s_acy, s_bcx, s_bcy;
    logic [32:0] s_sum, s_cross, s_p, s_vx, s_vy, s_t;
    logic [31:0] sh;
    logic        ge;
    logic [31:0] dmag;
    logic signed [PW-1:0] qsigned;

    assign sx = mem_q_reg[127:96];
    assign sy = mem_q_reg[95:64];
    assign ex = mem_q_reg[63:32];
    assign ey = mem_q_reg[31:0];

    // wall normal x component is -uy and may reach +2^31
    assign wx = -{uy_reg[31], uy_reg};

    // pick multiplier operands for this step
    always_comb begin
        case (cmd.op)
            ST_M_UXUX:  begin ma = 33'(ux_reg);    mb = 33'(ux_reg);    end
            ST_M_UYUY:  begin ma = 33'(uy_reg);    mb = 33'(uy_reg);    end
            ST_M_UYACX: begin ma = 33'(uy_reg);    mb = 33'(acx_reg);   end
            ST_M_UXACY: begin ma = 33'(ux_reg);    mb = 33'(acy_reg);   end
            ST_M_RR:    begin ma = {2'b00, r_reg}; mb = {2'b00, r_reg}; end
            ST_M_CC:    begin ma = 33'(cross_reg); mb = 33'(cross_reg); end
            ST_M_R2UU:  begin ma = 33'(r2_reg);    mb = 33'(uu_reg);    end
            ST_M_UXACX: begin ma = 33'(ux_reg);    mb = 33'(acx_reg);   end
            ST_M_UYACY: begin ma = 33'(uy_reg);    mb = 33'(acy_reg);   end
            ST_M_UXBCX: begin ma = 33'(ux_reg);    mb = 33'(bcx_reg);   end
            ST_M_UYBCY: begin ma = 33'(uy_reg);    mb = 33'(bcy_reg);   end
            ST_M_ACX2:  begin ma = 33'(acx_reg);   mb = 33'(acx_reg);   end
            ST_M_ACY2:  begin ma = 33'(acy_reg);   mb = 33'(acy_reg);   end
            ST_M_BCX2:  begin ma = 33'(bcx_reg);   mb = 33'(bcx_reg);   end
            ST_M_BCY2:  begin ma = 33'(bcy_reg);   mb = 33'(bcy_reg);   end
            ST_M_VXWX:  begin ma = 33'(vx_reg);    mb = wx;             end
            ST_M_VYWY:  begin ma = 33'(vy_reg);    mb = 33'(ux_reg);    end
            ST_M_TWX:   begin ma = 33'(t_reg);     mb = wx;             end
            ST_M_TWY:   begin ma = 33'(t_reg);     mb = 33'(ux_reg);    end
            default:    begin ma = '0;             mb = '0;             end
        endcase
    end

    // floor-scaled product: arithmetic shift drops 16 fraction bits
    assign prod    = ma * mb;
    assign pscaled = prod[65:16];

    // saturating differences and sums
    assign s_ux    = sat32(ext32(ex) - ext32(sx));
    assign s_uy    = sat32(ext32(ey) - ext32(sy));
    assign s_acx   = sat32(ext32(px_reg) - ext32(sx));
    assign s_acy   = sat32(ext32(py_reg) - ext32(sy));
    assign s_bcx   = sat32(ext32(px_reg) - ext32(ex));
    assign s_bcy   = sat32(ext32(py_reg) - ext32(ey));
    assign sum_pq  = extp(q_reg) + extp(p_reg);
    assign s_sum   = sat32(sum_pq);
    assign s_cross = sat32(extp(p_reg) - extp(q_reg));
    assign s_p     = sat32(extp(p_reg));
    assign s_vx    = sat32(ext32(vx_reg) - extp(p_reg));
    assign s_vy    = sat32(ext32(vy_reg) - extp(p_reg));

    // one restoring division step
    assign sh = {rem_reg, nq_reg[QW-1]};
    assign ge = (sh >= {1'b0, uu_reg[30:0]});

    assign dmag    = d_reg[31] ? 32'(-d_reg) : 32'(d_reg);
    assign qsigned = neg_reg ? -{1'b0, nq_reg} : {1'b0, nq_reg};
    assign s_t     = sat32(extp(qsigned));

    // status to the controller
    assign status.uu_zero  = (uu_reg == '0);
    assign status.line_hit = (lhs_reg < rhs_reg);
    assign status.seg_hit  = (d1ok_reg && d2ok_reg) || (a2_reg < r2_reg)
                             || (b2_reg < r2_reg);

    // wall table: write on a wall transfer, registered read
    always_ff @(posedge aclk) begin
        if (cmd.write_wall) begin
            mem[s_wall_index] <= {s_wall_start_x, s_wall_start_y,
                                  s_wall_end_x, s_wall_end_y};
        end
        mem_q_reg <= mem[cmd.idx];
    end

    // execute the current step
    always_ff @(posedge aclk) begin
        if (cmd.load_ball) begin
            px_reg   <= s_ball_x;
            py_reg   <= s_ball_y;
            r_reg    <= s_ball_radius;
            vx_reg   <= s_speed_in_x;
            vy_reg   <= s_speed_in_y;
            sat_reg  <= 1'b0;
            hits_reg <= '0;
        end
        if (cmd.load_out) begin
            m_speed_out_x <= vx_reg;
            m_speed_out_y <= vy_reg;
            m_hit_count   <= hits_reg;
            m_saturated   <= sat_reg;
        end
        case (cmd.op)
            ST_DIFF: begin
                ux_reg  <= s_ux[31:0];
                uy_reg  <= s_uy[31:0];
                acx_reg <= s_acx[31:0];
                acy_reg <= s_acy[31:0];
                bcx_reg <= s_bcx[31:0];
                bcy_reg <= s_bcy[31:0];
                sat_reg <= sat_reg | s_ux[32] | s_uy[32];
                // endpoint offsets only count once the wall has length
                pend_reg <= s_acx[32] | s_acy[32] | s_bcx[32] | s_bcy[32];
            end
            ST_M_UXUX: p_reg <= pscaled;
            ST_M_UYUY: begin
                q_reg <= p_reg;
                p_reg <= pscaled;
            end
            ST_M_UYACX: begin
                uu_reg  <= s_sum[31:0];
                sat_reg <= sat_reg | s_sum[32];
                p_reg   <= pscaled;
            end
            ST_M_UXACY: begin
                q_reg   <= p_reg;
                p_reg   <= pscaled;
                sat_reg <= sat_reg | pend_reg;
            end
            ST_M_RR: begin
                cross_reg <= s_cross[31:0];
                sat_reg   <= sat_reg | s_cross[32];
                p_reg     <= pscaled;
            end
            ST_M_CC: begin
                r2_reg  <= s_p[31:0];
                sat_reg <= sat_reg | s_p[32];
                p_reg   <= pscaled;
            end
            ST_M_R2UU: begin
                lhs_reg <= s_p[31:0];
                sat_reg <= sat_reg | s_p[32];
                p_reg   <= pscaled;
            end
            ST_S_RHS: begin
                rhs_reg <= s_p[31:0];
                sat_reg <= sat_reg | s_p[32];
            end
            ST_M_UXACX: p_reg <= pscaled;
            ST_M_UYACY: begin
                q_reg <= p_reg;
                p_reg <= pscaled;
            end
            ST_M_UXBCX: begin
                d1ok_reg <= !sum_pq[SW-1];
                p_reg    <= pscaled;
            end
            ST_M_UYBCY: begin
                q_reg <= p_reg;
                p_reg <= pscaled;
            end
            ST_M_ACX2: begin
                d2ok_reg <= sum_pq[SW-1] || (sum_pq == '0);
                p_reg    <= pscaled;
            end
            ST_M_ACY2: begin
                q_reg <= p_reg;
                p_reg <= pscaled;
            end
            ST_M_BCX2: begin
                a2_reg  <= s_sum[31:0];
                sat_reg <= sat_reg | s_sum[32];
                p_reg   <= pscaled;
            end
            ST_M_BCY2: begin
                q_reg <= p_reg;
                p_reg <= pscaled;
            end
            ST_S_B2: begin
                b2_reg  <= s_sum[31:0];
                sat_reg <= sat_reg | s_sum[32];
            end
            ST_M_VXWX: p_reg <= pscaled;
            ST_M_VYWY: begin
                q_reg <= p_reg;
                p_reg <= pscaled;
            end
            ST_S_D: begin
                d_reg   <= s_sum[31:0];
                sat_reg <= sat_reg | s_sum[32];
            end
            ST_DIV_INIT: begin
                nq_reg  <= {dmag, 17'b0};
                rem_reg <= '0;
                neg_reg <= d_reg[31];
            end
            ST_DIV_STEP: begin
                rem_reg <= ge ? 31'(sh - {1'b0, uu_reg[30:0]}) : sh[30:0];
                nq_reg  <= {nq_reg[QW-2:0], ge};
            end
            ST_S_T: begin
                t_reg   <= s_t[31:0];
                sat_reg <= sat_reg | s_t[32];
            end
            ST_M_TWX: p_reg <= pscaled;
            ST_M_TWY: begin
                vx_reg  <= s_vx[31:0];
                sat_reg <= sat_reg | s_vx[32];
                p_reg   <= pscaled;
            end
            ST_S_VY: begin
                vy_reg   <= s_vy[31:0];
                sat_reg  <= sat_reg | s_vy[32];
                hits_reg <= hits_reg + 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule
